@@ hdl/sdrf_pkg.sv @@
// Package for the shake-detect coin-flip unit: payload structs, command
// codes, reset constants and the internal operation record.
// No dependencies.
`default_nettype none

package sdrf_pkg;

  // Filter divisor is a power of two; truncation toward zero uses a bias
  localparam int FILTER_SHIFT   = 3;
  localparam int FILTER_DIVISOR = 1 << FILTER_SHIFT;

  localparam int THRESH_W = 18;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 18'd500;
  localparam logic [31:0]         RNG_SEED     = 32'h2545F491;

  // Default queue depths
  localparam int OP_Q_DEPTH  = 2;
  localparam int RES_Q_DEPTH = 2;

  // Input command codes
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TAP    = 2'd1;
  localparam logic [1:0] CMD_DONE   = 2'd2;
  localparam logic [1:0] CMD_SEED   = 2'd3;

  // Trigger source codes
  localparam logic SRC_SHAKE = 1'b0;
  localparam logic SRC_TAP   = 1'b1;

  typedef struct packed {
    logic [1:0]   cmd;
    logic [15:0]  accel_x;
    logic [15:0]  accel_y;
    logic [15:0]  accel_z;
  } in_item_t;

  typedef struct packed {
    logic         heads;
    logic         trigger_source;
    logic [31:0]  random_word;
  } out_result_t;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_TAP,
    OP_DONE,
    OP_SEED
  } op_kind_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    op_kind_t     kind;
    logic [15:0]  ax;
    logic [15:0]  ay;
    logic [15:0]  az;
    logic [31:0]  seed_mix;
  } op_t;

endpackage

`default_nettype wire

@@ hdl/sdrf_fifo.sv @@
// Small synchronous queue of any payload type for the shake-detect unit.
// Register storage, combinational read of the head entry. No dependencies.
`default_nettype none

module sdrf_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  output logic       full,
  input  wire item_t wr_item,
  input  wire logic  pop,
  output logic       empty,
  output item_t      rd_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr_r];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sdrf_front.sv @@
// Front end of the shake-detect unit: decodes each request, precomputes the
// seed-mix term and queues the result. Uses sdrf_pkg and sdrf_fifo.
`default_nettype none

module sdrf_front #(
  parameter int OP_DEPTH = sdrf_pkg::OP_Q_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire sdrf_pkg::in_item_t in_item,
  input  wire logic              op_pop,
  output logic                   op_empty,
  output sdrf_pkg::op_t          op
);

  import sdrf_pkg::*;

  op_t         op_in;
  logic [31:0] ux, uy, uz;

  // Widen the raw reading patterns
  assign ux = {16'd0, in_item.accel_x};
  assign uy = {16'd0, in_item.accel_y};
  assign uz = {16'd0, in_item.accel_z};

  // Decode the command and build the seed-mix term (x*31 ^ y*17 ^ z)
  always_comb begin
    op_in.ax       = in_item.accel_x;
    op_in.ay       = in_item.accel_y;
    op_in.az       = in_item.accel_z;
    op_in.seed_mix = ((ux << 5) - ux) ^ ((uy << 4) + uy) ^ uz;
    unique case (in_item.cmd)
      CMD_SAMPLE: op_in.kind = OP_SAMPLE;
      CMD_TAP:    op_in.kind = OP_TAP;
      CMD_DONE:   op_in.kind = OP_DONE;
      CMD_SEED:   op_in.kind = OP_SEED;
      default:    op_in.kind = OP_DONE;
    endcase
  end

  // Hold decoded requests until the back end takes them
  sdrf_fifo #(
    .item_t (op_t),
    .DEPTH  (OP_DEPTH)
  ) u_op_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .wr_item (op_in),
    .pop     (op_pop),
    .empty   (op_empty),
    .rd_item (op)
  );

endmodule

`default_nettype wire

@@ hdl/sdrf_back.sv @@
// Back end of the shake-detect unit: gravity filter, shake test, busy flag
// and xorshift32 generator; one request per cycle while res_full is low. Uses sdrf_pkg.
`default_nettype none

module sdrf_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [17:0]             cfg_wdata,
  input  wire logic                    op_empty,
  input  wire sdrf_pkg::op_t           op,
  output logic                         op_pop,
  input  wire logic                    res_full,
  output logic                         res_push,
  output sdrf_pkg::out_result_t        res
);

  import sdrf_pkg::*;

  logic [THRESH_W-1:0] thresh_r;
  logic                loaded_r, loaded_nxt;
  logic                busy_r, busy_nxt;
  logic [31:0]         rng_r, rng_nxt;
  logic [15:0]         est_r [3];
  logic [15:0]         est_nxt [3];
  logic [15:0]         samp [3];
  logic signed [16:0]  diff [3];
  logic signed [16:0]  quot [3];
  logic signed [16:0]  dev [3];
  logic [15:0]         dev_abs [3];
  logic [15:0]         est_upd [3];
  logic [THRESH_W-1:0] motion;
  logic [31:0]         rng_step;
  logic                fire;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] v;
    v = s ^ (s << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

  assign samp[0]  = op.ax;
  assign samp[1]  = op.ay;
  assign samp[2]  = op.az;
  assign fire     = !op_empty && !res_full;
  assign op_pop   = fire;
  assign rng_step = xorshift32(rng_r);

  // Filter each axis: step the estimate by diff/divisor, toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]    = $signed({samp[i][15], samp[i]}) - $signed({est_r[i][15], est_r[i]});
      quot[i]    = $signed(diff[i] + (diff[i][16] ? 17'(FILTER_DIVISOR - 1) : 17'd0))
                   >>> FILTER_SHIFT;
      est_upd[i] = est_r[i] + quot[i][15:0];
      dev[i]     = diff[i] - quot[i];
      dev_abs[i] = dev[i][16] ? 16'(-dev[i]) : dev[i][15:0];
    end
    motion = {2'b00, dev_abs[0]} + {2'b00, dev_abs[1]} + {2'b00, dev_abs[2]};
  end

  // Carry out the request at the head of the queue
  always_comb begin
    loaded_nxt = loaded_r;
    busy_nxt   = busy_r;
    rng_nxt    = rng_r;
    res_push   = 1'b0;
    res.heads          = rng_step[31];
    res.trigger_source = SRC_TAP;
    res.random_word    = rng_step;
    for (int i = 0; i < 3; i++) begin
      est_nxt[i] = est_r[i];
    end
    if (fire) begin
      if (op.kind == OP_DONE) begin
        busy_nxt = 1'b0;
      end else if (!busy_r) begin
        unique case (op.kind)
          OP_TAP: begin
            rng_nxt  = rng_step;
            busy_nxt = 1'b1;
            res_push = 1'b1;
          end
          OP_SEED: begin
            rng_nxt = rng_r ^ op.seed_mix ^ {rng_r[30:0], 1'b0};
          end
          OP_SAMPLE: begin
            if (!loaded_r) begin
              for (int i = 0; i < 3; i++) begin
                est_nxt[i] = samp[i];
              end
              loaded_nxt = 1'b1;
            end else begin
              for (int i = 0; i < 3; i++) begin
                est_nxt[i] = est_upd[i];
              end
              if (motion >= thresh_r) begin
                loaded_nxt         = 1'b0;
                rng_nxt            = rng_step;
                busy_nxt           = 1'b1;
                res_push           = 1'b1;
                res.trigger_source = SRC_SHAKE;
              end
            end
          end
          default: begin
            busy_nxt = busy_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      loaded_r <= 1'b0;
      busy_r   <= 1'b0;
      rng_r    <= RNG_SEED;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      loaded_r <= loaded_nxt;
      busy_r   <= busy_nxt;
      rng_r    <= rng_nxt;
    end
  end

  // Estimate is only read once loaded, so it needs no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      est_r[i] <= est_nxt[i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/shake_detect_random_flip_unit.sv @@
// Top level of the shake-detect coin-flip unit: front decoder queue, back
// execution unit and result queue. Uses sdrf_pkg, sdrf_front, sdrf_back, sdrf_fifo.
//
//   channel   handshake          payload
//   -------   ----------------   ------------------------------
//   input     push / full        in_item  (sdrf_pkg::in_item_t)
//   result    empty / pop        out_result (sdrf_pkg::out_result_t)
//   config    cfg_we             cfg_wdata (motion threshold)
//
// One request per cycle end to end; a result is visible the cycle after the
// back end executes it. Throughput is set by the back end, which retires one
// request per cycle. The back end stalls only while the result queue is full;
// the input queue keeps taking requests until it fills. Reset is synchronous;
// both queues come out empty and the threshold returns to 500.
`default_nettype none

module shake_detect_random_flip_unit #(
  parameter int OP_DEPTH  = sdrf_pkg::OP_Q_DEPTH,
  parameter int RES_DEPTH = sdrf_pkg::RES_Q_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  output logic                        full,
  input  wire sdrf_pkg::in_item_t     in_item,
  output logic                        empty,
  input  wire logic                   pop,
  output sdrf_pkg::out_result_t       out_result,
  input  wire logic                   cfg_we,
  input  wire logic [17:0]            cfg_wdata
);

  import sdrf_pkg::*;

  op_t         op;
  logic        op_empty, op_pop;
  logic        res_push, res_full;
  out_result_t res;

  // Decode and queue incoming requests
  sdrf_front #(
    .OP_DEPTH (OP_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .op_pop   (op_pop),
    .op_empty (op_empty),
    .op       (op)
  );

  // Execute requests against the filter and generator state
  sdrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .op_empty  (op_empty),
    .op        (op),
    .op_pop    (op_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Hold flip results until taken
  sdrf_fifo #(
    .item_t (out_result_t),
    .DEPTH  (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .full    (res_full),
    .wr_item (res),
    .pop     (pop),
    .empty   (empty),
    .rd_item (out_result)
  );

  // Never drop a result on a full queue
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // Outcome is the top bit of the generator word
  a_heads_matches_word: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_result.heads == out_result.random_word[31]))
    else $error("heads does not match random word");

  // Reset empties both sides
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!full && empty))
    else $error("queues not empty after reset");

  // Back end only consumes a request when one is waiting
  a_pop_needs_op: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |-> !op_empty)
    else $error("back end popped an empty queue");

endmodule

`default_nettype wire
